/* rtl/rtfx_pkg.sv */
package rtfx_pkg;

   localparam int KW_LEN = 18;
   localparam int KW_BITS = 8 * KW_LEN;
   localparam int SKIP_COUNT = 23;
   localparam logic [4:0] LEN_MAX = 5'd31;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_BRACE,
      MODE_BRACE_ESC,
      MODE_ESC,
      MODE_WORD,
      MODE_PARAM,
      MODE_HEX1,
      MODE_HEX2
   } rtfx_mode_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last;
   } rtfx_req_type;

   typedef struct packed {
      logic [15:0] text_unit;
      logic        has_text;
      logic        run_last;
      logic        text_end;
   } rtfx_rsp_type;

   typedef struct packed {
      logic [1:0]   count;
      rtfx_rsp_type first;
      rtfx_rsp_type second;
   } rtfx_emit_type;

   typedef logic [KW_LEN-1:0][6:0] rtfx_letters_type;

   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_LBRACE    = 16'h007B;
   localparam logic [15:0] CH_RBRACE    = 16'h007D;
   localparam logic [15:0] CH_STAR      = 16'h002A;
   localparam logic [15:0] CH_QUOTE     = 16'h0027;
   localparam logic [15:0] CH_TILDE     = 16'h007E;
   localparam logic [15:0] CH_UNDER     = 16'h005F;
   localparam logic [15:0] CH_MINUS     = 16'h002D;
   localparam logic [15:0] CH_SPACE     = 16'h0020;
   localparam logic [15:0] CH_NEWLINE   = 16'h000A;
   localparam logic [15:0] CH_TAB       = 16'h0009;
   localparam logic [15:0] CH_NBSP      = 16'h00A0;
   localparam logic [15:0] CH_NBHYPHEN  = 16'h2011;

   localparam logic [KW_BITS-1:0] KW_PAR  = "par";
   localparam logic [KW_BITS-1:0] KW_LINE = "line";
   localparam logic [KW_BITS-1:0] KW_TAB  = "tab";
   localparam logic [KW_BITS-1:0] KW_U    = "u";

   localparam logic [KW_BITS-1:0] SKIP_WORDS [SKIP_COUNT] = '{
      "fonttbl", "colortbl", "stylesheet", "info", "pict", "header", "footer",
      "footerl", "footerr", "footnote", "bkmkstart", "bkmkend", "fldinst",
      "listtable", "listoverridetable", "rsidtbl", "generator", "filetbl",
      "revtbl", "xmlnstbl", "datastore", "themedata", "colorschememapping"
   };
   localparam logic [4:0] SKIP_LENS [SKIP_COUNT] = '{
      5'd7, 5'd8, 5'd10, 5'd4, 5'd4, 5'd6, 5'd6, 5'd7, 5'd7, 5'd8, 5'd9, 5'd7,
      5'd7, 5'd9, 5'd17, 5'd7, 5'd9, 5'd7, 5'd6, 5'd8, 5'd9, 5'd9, 5'd18
   };

   function automatic logic is_alpha(input logic [15:0] c);
      return (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A);
   endfunction

   function automatic logic is_digit(input logic [15:0] c);
      return c >= 16'h0030 && c <= 16'h0039;
   endfunction

   function automatic logic [3:0] hex_val(input logic [15:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (is_digit(c)) v = c[3:0];
      else if (c >= 16'h0061 && c <= 16'h0066) v = 4'(c[3:0] + 4'd9);
      else if (c >= 16'h0041 && c <= 16'h0046) v = 4'(c[3:0] + 4'd9);
      return v;
   endfunction

   function automatic logic word_eq(input rtfx_letters_type l, input logic [4:0] len,
                                    input logic [KW_BITS-1:0] kw, input logic [4:0] n);
      logic ok;
      int   base;
      ok = (len == n);
      for (int i = 0; i < KW_LEN; i++) begin
         base = 8 * (int'(n) - 1 - i);
         if (i < int'(n) && base >= 0) begin
            if (l[i] != kw[base +: 7]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic word_skipped(input rtfx_letters_type l, input logic [4:0] len);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < SKIP_COUNT; k++) begin
         if (word_eq(l, len, SKIP_WORDS[k], SKIP_LENS[k])) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

/* rtl/rtfx_lexer.sv */
module rtfx_lexer #(
   parameter int MAX_WORD = 17,
   parameter int DEPTH_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  rtfx_pkg::rtfx_req_type req,
   output rtfx_pkg::rtfx_emit_type emit
);
   import rtfx_pkg::*;

   localparam int SLOTS = MAX_WORD + 1;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

   rtfx_mode_type         mode_ff, mode_in;
   logic [6:0]            letters_ff [SLOTS];
   logic [6:0]            letters_in [SLOTS];
   logic [4:0]            length_ff, length_in;
   logic                  follows_ff, follows_in;
   logic [15:0]           pv_ff, pv_in;
   logic                  neg_ff, neg_in;
   logic                  present_ff, present_in;
   logic [15:0]           hex_ff, hex_in;
   logic                  drop_ff, drop_in;
   logic                  skip_ff, skip_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [DEPTH_BITS-1:0] start_ff, start_in;

   logic [15:0]           e0, e1;
   logic [1:0]            n_emit;

   rtfx_letters_type      lcur, lnew;

   always_comb begin
      for (int i = 0; i < KW_LEN; i++) begin
         lcur[i] = letters_ff[i];
         lnew[i] = letters_in[i];
      end
   end

   always_comb begin
      logic [15:0] c;
      logic        last;
      logic        do_idle, do_wa, do_esc, esc_brace, drop;
      logic [15:0] uval;
      c = req.code_unit;
      last = req.last;
      do_idle = 1'b0;
      do_wa = 1'b0;
      do_esc = 1'b0;
      esc_brace = 1'b0;
      drop = 1'b0;
      uval = 16'd0;
      e0 = 16'd0;
      e1 = 16'd0;
      n_emit = 2'd0;
      mode_in = mode_ff;
      letters_in = letters_ff;
      length_in = length_ff;
      follows_in = follows_ff;
      pv_in = pv_ff;
      neg_in = neg_ff;
      present_in = present_ff;
      hex_in = hex_ff;
      drop_in = drop_ff;
      skip_in = skip_ff;
      depth_in = depth_ff;
      start_in = start_ff;

      unique case (mode_ff)
         MODE_BRACE: begin
            if (c == CH_BACKSLASH) mode_in = MODE_BRACE_ESC;
            else do_idle = 1'b1;
         end
         MODE_BRACE_ESC: begin
            if (c == CH_STAR) begin
               if (!skip_in) begin
                  skip_in = 1'b1;
                  start_in = depth_in;
               end
               mode_in = MODE_IDLE;
            end else begin
               do_esc = 1'b1;
               esc_brace = 1'b1;
            end
         end
         MODE_ESC: do_esc = 1'b1;
         MODE_WORD: begin
            if (is_alpha(c)) begin
               for (int j = 0; j < SLOTS; j++) begin
                  if (int'(length_ff) == j) letters_in[j] = c[6:0];
               end
               if (length_ff < LEN_MAX) length_in = 5'(length_ff + 5'd1);
            end else if (follows_ff && word_skipped(lcur, length_ff)) begin
               if (!skip_in) begin
                  skip_in = 1'b1;
                  start_in = depth_in;
               end
               do_idle = 1'b1;
            end else if (c == CH_MINUS || is_digit(c)) begin
               present_in = 1'b1;
               if (c == CH_MINUS) neg_in = 1'b1;
               else pv_in = {12'd0, c[3:0]};
               mode_in = MODE_PARAM;
            end else begin
               do_wa = 1'b1;
               do_idle = (c != CH_SPACE);
            end
         end
         MODE_PARAM: begin
            if (is_digit(c)) begin
               pv_in = 16'((pv_ff << 3) + (pv_ff << 1) + {12'd0, c[3:0]});
            end else begin
               do_wa = 1'b1;
               do_idle = (c != CH_SPACE);
            end
         end
         MODE_HEX1: begin
            if (last) do_idle = 1'b1;
            else begin
               hex_in = c;
               mode_in = MODE_HEX2;
            end
         end
         MODE_HEX2: begin
            if (!drop_ff) begin
               e0 = {8'd0, hex_val(hex_ff), hex_val(c)};
               n_emit = 2'd1;
            end
            drop_in = 1'b0;
            mode_in = MODE_IDLE;
         end
         default: do_idle = 1'b1;
      endcase

      if (do_esc) begin
         if (c == CH_QUOTE) begin
            mode_in = MODE_HEX1;
         end else begin
            drop_in = 1'b0;
            mode_in = MODE_IDLE;
            if (is_alpha(c)) begin
               letters_in[0] = c[6:0];
               length_in = 5'd1;
               follows_in = esc_brace;
               pv_in = 16'd0;
               neg_in = 1'b0;
               present_in = 1'b0;
               mode_in = MODE_WORD;
            end else if (c == CH_TILDE) begin
               e0 = CH_NBSP;
               n_emit = 2'd1;
            end else if (c == CH_UNDER) begin
               e0 = CH_NBHYPHEN;
               n_emit = 2'd1;
            end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_BACKSLASH) begin
               e0 = c;
               n_emit = 2'd1;
            end
         end
      end

      if (do_wa) begin
         mode_in = MODE_IDLE;
         uval = neg_ff ? 16'(16'd0 - pv_ff) : pv_ff;
         if (word_eq(lcur, length_ff, KW_PAR, 5'd3) || word_eq(lcur, length_ff, KW_LINE, 5'd4)) begin
            e0 = CH_NEWLINE;
            n_emit = 2'd1;
         end else if (word_eq(lcur, length_ff, KW_TAB, 5'd3)) begin
            e0 = CH_TAB;
            n_emit = 2'd1;
         end else if (word_eq(lcur, length_ff, KW_U, 5'd1) && present_ff) begin
            e0 = uval;
            n_emit = 2'd1;
            drop_in = 1'b1;
         end
      end

      if (do_idle) begin
         drop = drop_in;
         drop_in = 1'b0;
         mode_in = MODE_IDLE;
         if (c == CH_LBRACE) begin
            if (depth_in != DEPTH_MAX) depth_in = DEPTH_BITS'(depth_in + 1'b1);
            mode_in = skip_in ? MODE_IDLE : MODE_BRACE;
         end else if (c == CH_RBRACE) begin
            if (depth_in != '0) begin
               if (skip_in && depth_in <= start_in) skip_in = 1'b0;
               depth_in = DEPTH_BITS'(depth_in - 1'b1);
            end else begin
               skip_in = 1'b0;
            end
         end else if (!skip_in) begin
            if (c == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
               drop_in = drop;
            end else if (n_emit == 2'd0) begin
               e0 = c;
               n_emit = 2'd1;
            end else begin
               e1 = c;
               n_emit = 2'd2;
            end
         end
      end

      if (last) begin
         uval = neg_in ? 16'(16'd0 - pv_in) : pv_in;
         if ((mode_in == MODE_WORD && !(follows_in && word_skipped(lnew, length_in)))
             || mode_in == MODE_PARAM) begin
            if (word_eq(lnew, length_in, KW_PAR, 5'd3)
                || word_eq(lnew, length_in, KW_LINE, 5'd4)) begin
               e0 = CH_NEWLINE;
               n_emit = 2'd1;
            end else if (word_eq(lnew, length_in, KW_TAB, 5'd3)) begin
               e0 = CH_TAB;
               n_emit = 2'd1;
            end else if (word_eq(lnew, length_in, KW_U, 5'd1) && present_in) begin
               e0 = uval;
               n_emit = 2'd1;
            end
         end
         mode_in = MODE_IDLE;
         length_in = 5'd0;
         follows_in = 1'b0;
         pv_in = 16'd0;
         neg_in = 1'b0;
         present_in = 1'b0;
         hex_in = 16'd0;
         drop_in = 1'b0;
         skip_in = 1'b0;
         depth_in = '0;
         start_in = '0;
      end
   end

   always_comb begin
      emit.count = 2'd0;
      emit.first = '0;
      emit.second = '0;
      unique case (n_emit)
         2'd0: begin
            if (req.last) begin
               emit.count = 2'd1;
               emit.first = '{text_unit: 16'd0, has_text: 1'b0, run_last: 1'b1, text_end: 1'b1};
            end
         end
         2'd1: begin
            emit.count = 2'd1;
            emit.first = '{text_unit: e0, has_text: 1'b1, run_last: 1'b1, text_end: req.last};
         end
         default: begin
            emit.count = 2'd2;
            emit.first = '{text_unit: e0, has_text: 1'b1, run_last: 1'b0, text_end: 1'b0};
            emit.second = '{text_unit: e1, has_text: 1'b1, run_last: 1'b1, text_end: req.last};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         length_ff <= 5'd0;
         follows_ff <= 1'b0;
         pv_ff <= 16'd0;
         neg_ff <= 1'b0;
         present_ff <= 1'b0;
         hex_ff <= 16'd0;
         drop_ff <= 1'b0;
         skip_ff <= 1'b0;
         depth_ff <= '0;
         start_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         length_ff <= length_in;
         follows_ff <= follows_in;
         pv_ff <= pv_in;
         neg_ff <= neg_in;
         present_ff <= present_in;
         hex_ff <= hex_in;
         drop_ff <= drop_in;
         skip_ff <= skip_in;
         depth_ff <= depth_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) letters_ff <= letters_in;
   end

endmodule

/* rtl/rtf_text_extractor_unit.sv */
// RTF to plain text extractor.
// req channel: one RTF code unit per transaction, with last on the final unit
// of the document. rsp channel: plain text code units; has_text is 0 on a bare
// end marker, run_last closes the results of one input unit and text_end
// closes the document.
// Each input unit gives zero, one or two results. The lexer state updates in
// the cycle of acceptance and its results are registered in a four-entry
// result queue before they are offered.
// Throughput is one code unit per cycle while each unit gives at most one
// result and the receiver does not stall; a unit that gives two results is
// drained through the single read port of the result queue.
// req_stall rises while fewer than two queue entries are free, so a stalled
// receiver backs up into the request side without loss.
// Reset clears lexer state and empties the queue; the block can accept a
// transaction as soon as reset is released.
module rtf_text_extractor_unit #(
   parameter int MAX_WORD = 17,
   parameter int DEPTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rtfx_pkg::rtfx_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rtfx_pkg::rtfx_rsp_type rsp_payload
);
   import rtfx_pkg::*;

   rtfx_emit_type emit;
   rtfx_rsp_type  queue_ff [4];
   logic [1:0]    wp_ff, wp_in;
   logic [1:0]    rp_ff, rp_in;
   logic [2:0]    count_ff, count_in;
   logic          accept, pop;

   assign req_stall = (count_ff > 3'd2);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_payload = queue_ff[rp_ff];
   assign pop = rsp_valid && !rsp_stall;

   rtfx_lexer #(
      .MAX_WORD(MAX_WORD),
      .DEPTH_BITS(DEPTH_BITS)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_payload),
      .emit(emit)
   );

   always_comb begin
      logic [1:0] pushed;
      pushed = accept ? emit.count : 2'd0;
      wp_in = 2'(wp_ff + pushed);
      rp_in = pop ? 2'(rp_ff + 2'd1) : rp_ff;
      count_in = 3'(count_ff + {1'b0, pushed} - {2'd0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 2'd0;
         rp_ff <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit.count != 2'd0) queue_ff[wp_ff] <= emit.first;
      if (accept && emit.count == 2'd2) queue_ff[2'(wp_ff + 2'd1)] <= emit.second;
   end

endmodule
